// ===== rtl/array_binary_tree_traversal_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array binary tree traversal block
// ----------------------------------------------------------------------------
`ifndef ARRAY_BINARY_TREE_TRAVERSAL_ASSERT_SVH
`define ARRAY_BINARY_TREE_TRAVERSAL_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define ABTT_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the cycle after the trigger
`define ABTT_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/abtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtt_pkg
// Shared types and constants of the array binary tree traversal block.
// ----------------------------------------------------------------------------
package abtt_pkg;

	localparam int TABLE_DEPTH = 63;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CHILD_W     = IDX_W + 1;
	localparam int STACK_DEPTH = $clog2(TABLE_DEPTH + 1);
	localparam int STK_W       = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_WALK  = 2'd2;

	localparam logic [1:0] ORD_IN   = 2'd0;
	localparam logic [1:0] ORD_PRE  = 2'd1;
	localparam logic [1:0] ORD_POST = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_MID  = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [6:0]         node_index;
		logic signed [31:0] node_value;
		logic [1:0]         walk_order;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic                   wr_en;
		logic                   clr;
		logic [IDX_W-1:0]       addr;
		logic [VALUE_WIDTH-1:0] wdata;
	} tbl_req_t;

	typedef struct packed {
		logic                   present;
		logic [VALUE_WIDTH-1:0] value;
	} tbl_rsp_t;

endpackage

// ===== rtl/abtt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtt_table
// Node table: one-port memory with per-slot valid bits and registered read.
// ----------------------------------------------------------------------------
module abtt_table (
	input  logic               clk,
	input  logic               arst_n,
	input  abtt_pkg::tbl_req_t req,
	output abtt_pkg::tbl_rsp_t rsp
);

	logic [abtt_pkg::VALUE_WIDTH-1:0] mem_q [abtt_pkg::TABLE_DEPTH];
	logic [abtt_pkg::TABLE_DEPTH-1:0] vld_q;
	logic [abtt_pkg::VALUE_WIDTH-1:0] rd_data_q;
	logic                             rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[req.addr];
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
		end
	end

	assign rsp.present = rd_vld_q && (rd_data_q != '1);
	assign rsp.value   = rd_data_q;

endmodule

// ===== rtl/array_binary_tree_traversal.sv =====
// Write and clear: result registered in the cycle after acceptance. Unused requests
// are accepted but give no result. Traverse: a root read and check, then per node a
// step per phase, plus a table read for each child slot in range. The single
// table read port and one stack step per cycle (unless rsp stalls) set the walk rate.
// Reset empties the table at once through per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_traversal
// Array-held binary tree with write, clear and stack-driven order walks.
// ----------------------------------------------------------------------------
`include "array_binary_tree_traversal_assert.svh"

module array_binary_tree_traversal (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  abtt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output abtt_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_RCHK,
		S_STEP,
		S_CHK,
		S_LAST
	} state_t;

	state_t                                  state_q;
	logic [abtt_pkg::SP_W-1:0]               sp_q;
	logic [1:0]                              emit_ph_q;
	logic                                    pend_v_q;
	logic signed [abtt_pkg::VALUE_WIDTH-1:0] pend_q;
	logic [abtt_pkg::IDX_W-1:0]              child_q;
	logic                                    rsp_v_q;
	abtt_pkg::rsp_t                          rsp_q;

	logic [abtt_pkg::IDX_W-1:0]              stk_idx_q [abtt_pkg::STACK_DEPTH];
	logic [1:0]                              stk_ph_q  [abtt_pkg::STACK_DEPTH];
	logic signed [abtt_pkg::VALUE_WIDTH-1:0] stk_val_q [abtt_pkg::STACK_DEPTH];

	abtt_pkg::tbl_req_t tbl_req;
	abtt_pkg::tbl_rsp_t tbl_rsp;

	logic                                    rsp_free;
	logic                                    acc;
	logic                                    wr_ok;
	logic [abtt_pkg::SP_W-1:0]               sp_m1;
	logic [abtt_pkg::STK_W-1:0]              top_sel;
	logic [abtt_pkg::STK_W-1:0]              push_sel;
	logic [abtt_pkg::IDX_W-1:0]              cur_idx;
	logic [1:0]                              cur_ph;
	logic signed [abtt_pkg::VALUE_WIDTH-1:0] cur_val;
	logic [abtt_pkg::CHILD_W-1:0]            child_w;
	logic                                    child_ok;
	logic                                    emit;
	logic                                    step_go;
	logic                                    descend;
	logic                                    push_en;

	abtt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	assign rsp_free  = !rsp_v_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) ||
		(!rsp_free && (req.req_type == abtt_pkg::REQ_WRITE ||
		               req.req_type == abtt_pkg::REQ_CLEAR));
	assign acc       = req_valid && !req_stall;
	assign wr_ok     = req.node_index < 7'(abtt_pkg::TABLE_DEPTH);

	assign sp_m1    = sp_q - abtt_pkg::SP_W'(1);
	assign top_sel  = sp_m1[abtt_pkg::STK_W-1:0];
	assign push_sel = sp_q[abtt_pkg::STK_W-1:0];
	assign cur_idx  = stk_idx_q[top_sel];
	assign cur_ph   = stk_ph_q[top_sel];
	assign cur_val  = stk_val_q[top_sel];

	assign child_w  = {cur_idx, 1'b0} + abtt_pkg::CHILD_W'(1) + abtt_pkg::CHILD_W'(cur_ph[0]);
	assign child_ok = child_w < abtt_pkg::CHILD_W'(abtt_pkg::TABLE_DEPTH);

	assign emit    = (cur_ph == emit_ph_q);
	assign step_go = (state_q == S_STEP) && !(emit && pend_v_q && !rsp_free);
	assign descend = (cur_ph == abtt_pkg::PH_PRE) || (cur_ph == abtt_pkg::PH_MID);
	assign push_en = ((state_q == S_RCHK) || (state_q == S_CHK)) && tbl_rsp.present;

	always_comb begin
		tbl_req.wr_en = acc && (req.req_type == abtt_pkg::REQ_WRITE) && wr_ok;
		tbl_req.clr   = acc && (req.req_type == abtt_pkg::REQ_CLEAR);
		tbl_req.wdata = abtt_pkg::VALUE_WIDTH'(req.node_value);
		tbl_req.addr  = '0;
		if (tbl_req.wr_en) begin
			tbl_req.addr = req.node_index[abtt_pkg::IDX_W-1:0];
		end else if (state_q == S_STEP && child_ok) begin
			tbl_req.addr = child_w[abtt_pkg::IDX_W-1:0];
		end
	end

	// walk stack entries are written before they are read
	always_ff @(posedge clk) begin
		if (push_en) begin
			stk_idx_q[push_sel] <= (state_q == S_RCHK) ? '0 : child_q;
			stk_ph_q[push_sel]  <= abtt_pkg::PH_PRE;
			stk_val_q[push_sel] <= tbl_rsp.value;
		end else if (step_go && descend) begin
			stk_ph_q[top_sel] <= cur_ph + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			emit_ph_q <= abtt_pkg::PH_MID;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			child_q   <= '0;
			rsp_v_q   <= 1'b0;
			rsp_q     <= '0;
		end else begin
			if (rsp_v_q && !rsp_stall) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req.req_type)
							abtt_pkg::REQ_WRITE: begin
								rsp_v_q       <= 1'b1;
								rsp_q.out_value <= '0;
								rsp_q.status  <= wr_ok ? abtt_pkg::ST_OK : abtt_pkg::ST_RANGE;
								rsp_q.last    <= 1'b1;
							end
							abtt_pkg::REQ_CLEAR: begin
								rsp_v_q       <= 1'b1;
								rsp_q.out_value <= '0;
								rsp_q.status  <= abtt_pkg::ST_OK;
								rsp_q.last    <= 1'b1;
							end
							abtt_pkg::REQ_WALK: begin
								state_q <= S_ROOT;
								unique case (req.walk_order)
									abtt_pkg::ORD_PRE:  emit_ph_q <= abtt_pkg::PH_PRE;
									abtt_pkg::ORD_POST: emit_ph_q <= abtt_pkg::PH_POST;
									default:            emit_ph_q <= abtt_pkg::PH_MID;
								endcase
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ROOT: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (tbl_rsp.present) begin
						sp_q    <= abtt_pkg::SP_W'(1);
						state_q <= S_STEP;
					end else if (rsp_free) begin
						rsp_v_q         <= 1'b1;
						rsp_q.out_value <= '0;
						rsp_q.status    <= abtt_pkg::ST_EMPTY;
						rsp_q.last      <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_STEP: begin
					if (step_go) begin
						if (emit) begin
							pend_q   <= cur_val;
							pend_v_q <= 1'b1;
							if (pend_v_q) begin
								rsp_v_q         <= 1'b1;
								rsp_q.out_value <= 32'(pend_q);
								rsp_q.status    <= abtt_pkg::ST_OK;
								rsp_q.last      <= 1'b0;
							end
						end
						if (descend) begin
							if (child_ok) begin
								child_q <= child_w[abtt_pkg::IDX_W-1:0];
								state_q <= S_CHK;
							end
						end else begin
							sp_q <= sp_m1;
							if (sp_q == abtt_pkg::SP_W'(1)) begin
								state_q <= S_LAST;
							end
						end
					end
				end
				S_CHK: begin
					if (tbl_rsp.present) begin
						sp_q <= sp_q + abtt_pkg::SP_W'(1);
					end
					state_q <= S_STEP;
				end
				S_LAST: begin
					if (rsp_free) begin
						rsp_v_q         <= 1'b1;
						rsp_q.out_value <= 32'(pend_q);
						rsp_q.status    <= abtt_pkg::ST_OK;
						rsp_q.last      <= 1'b1;
						pend_v_q        <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	`ABTT_CHK_SAME(a_idle_stack_empty, state_q == S_IDLE, sp_q == '0, "stack not empty in idle")
	`ABTT_CHK_SAME(a_sp_bound, 1'b1, sp_q <= abtt_pkg::SP_W'(abtt_pkg::STACK_DEPTH), "stack overflow")
	`ABTT_CHK_SAME(a_walk_stack_live, state_q == S_STEP || state_q == S_CHK, sp_q != '0, "walk with empty stack")
	`ABTT_CHK_SAME(a_last_pending, state_q == S_LAST, pend_v_q, "final transaction missing")
	`ABTT_CHK_NEXT(a_single_rsp, acc && (req.req_type == abtt_pkg::REQ_WRITE || req.req_type == abtt_pkg::REQ_CLEAR), rsp_v_q && rsp_q.last, "write or clear transaction lost")

endmodule
